// ===== hdl/hsv_to_rgb_auto_brightness_assert.svh =====
`ifndef HSV_TO_RGB_AUTO_BRIGHTNESS_ASSERT_SVH
`define HSV_TO_RGB_AUTO_BRIGHTNESS_ASSERT_SVH

// Checks that apply once reset has been released.
`define HSVAB_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that also cover the reset cycles.
`define HSVAB_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hsvab_pkg.sv =====
package hsvab_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned LIGHT_W = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned DIST_W  = 10;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic REG_AUTO_MIN = 1'b0;
  localparam logic REG_AUTO_MAX = 1'b1;

  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic [PCT_W-1:0]  sat;
    logic [PCT_W-1:0]  val;
    logic [DIST_W-1:0] hue_dev;
    sector_t           sector;
  } work_t;

endpackage

// ===== hdl/hsvab_front.sv =====
module hsvab_front (
  input  logic [hsvab_pkg::HUE_W-1:0]   hue,
  input  logic [hsvab_pkg::PCT_W-1:0]   saturation,
  input  logic [hsvab_pkg::PCT_W-1:0]   brightness,
  input  logic [hsvab_pkg::LIGHT_W-1:0] light_level,
  input  logic [hsvab_pkg::PCT_W-1:0]   auto_min_level,
  input  logic [hsvab_pkg::PCT_W-1:0]   auto_max_level,
  output hsvab_pkg::work_t              work
);
  import hsvab_pkg::*;

  logic [PCT_W-1:0]  sat_c;
  logic [PCT_W-1:0]  val_c;
  logic [PCT_W-1:0]  lo;
  logic [PCT_W-1:0]  hi;
  logic              up;
  logic [PCT_W-1:0]  span;
  logic [14:0]       prod;
  logic [15:0]       prod_adj;
  logic [PCT_W-1:0]  step;
  logic [PCT_W-1:0]  val_auto;
  logic [19:0]       third;
  logic [13:0]       phase_raw;
  logic [10:0]       phase;

  always_comb begin
    sat_c = (saturation > PCT_MAX) ? PCT_MAX : saturation;
    val_c = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    lo    = (auto_min_level > PCT_MAX) ? PCT_MAX : auto_min_level;
    hi    = (auto_max_level > PCT_MAX) ? PCT_MAX : auto_max_level;
    up    = (hi >= lo);
    span  = up ? (hi - lo) : (lo - hi);
    prod  = 15'(light_level * span);
    // Division by 255 is exact in this form for the whole product range.
    prod_adj = 16'(prod) + 16'd1 + 16'(prod[14:8]);
    step     = prod_adj[14:8];
    val_auto = up ? (lo + step) : (lo - step);
  end

  always_comb begin
    // The phase is floor(50h/3), taken as 16h plus floor(2h/3).
    third     = 20'(hue * 11'd1366);
    phase_raw = {1'b0, hue, 4'b0000} + 14'(third[19:11]);
    if (phase_raw >= 14'd8000) begin
      phase = 11'(phase_raw - 14'd8000);
    end else if (phase_raw >= 14'd6000) begin
      phase = 11'(phase_raw - 14'd6000);
    end else if (phase_raw >= 14'd4000) begin
      phase = 11'(phase_raw - 14'd4000);
    end else if (phase_raw >= 14'd2000) begin
      phase = 11'(phase_raw - 14'd2000);
    end else begin
      phase = phase_raw[10:0];
    end
  end

  always_comb begin
    work.sat     = sat_c;
    work.val     = (val_c == '0) ? val_auto : val_c;
    work.hue_dev = (phase >= 11'd1000) ? DIST_W'(phase - 11'd1000)
                                       : DIST_W'(11'd1000 - phase);
    if (hue < 9'd60) begin
      work.sector = SECT_RY;
    end else if (hue < 9'd120) begin
      work.sector = SECT_YG;
    end else if (hue < 9'd180) begin
      work.sector = SECT_GC;
    end else if (hue < 9'd240) begin
      work.sector = SECT_CB;
    end else if (hue < 9'd300) begin
      work.sector = SECT_BM;
    end else begin
      work.sector = SECT_MR;
    end
  end

endmodule

// ===== hdl/hsvab_queue.sv =====
module hsvab_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hsvab_pkg::work_t push_data,
  input  logic             pop,
  output hsvab_pkg::work_t head,
  output logic             not_empty,
  output logic             full
);
  import hsvab_pkg::*;

  work_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign do_push   = push && (count != 2'd2);
  assign do_pop    = pop && (count != 2'd0);
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/hsvab_back.sv =====
module hsvab_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  hsvab_pkg::work_t               work,
  output logic                           done,
  output logic [hsvab_pkg::CHAN_W-1:0]   red,
  output logic [hsvab_pkg::CHAN_W-1:0]   green,
  output logic [hsvab_pkg::CHAN_W-1:0]   blue
);
  import hsvab_pkg::*;

  logic              vld1;
  logic              vld2;
  logic              vld3;
  sector_t           sec1;
  sector_t           sec2;
  sector_t           sec3;
  logic [PCT_W-1:0]  val1;
  logic [16:0]       sd1;
  logic [13:0]       wz1;
  logic [10:0]       fz1;
  logic [23:0]       p2;
  logic [15:0]       zz2;
  logic [CHAN_W-1:0] full2;
  logic [21:0]       ry3;
  logic [CHAN_W-1:0] zero3;
  logic [CHAN_W-1:0] full3;
  logic [16:0]       t2;
  logic [19:0]       zmul;
  logic [21:0]       fmul;
  logic [29:0]       rmul;
  logic [30:0]       zq;
  logic [44:0]       rq;
  logic [CHAN_W-1:0] ramp;

  // Every channel is 255 times a product over a power of ten, reduced here
  // to a small factor, a shift and a reciprocal multiply that is exact over
  // the range in use.
  assign t2   = 17'd100000 - sd1;
  assign zmul = 20'(wz1 * 6'd51);
  assign fmul = 22'(fz1 * 11'd1639);
  assign rmul = 30'(p2 * 6'd51);
  assign zq   = 31'(zz2 * 16'd33555);
  assign rq   = 45'(ry3 * 23'd4398047);
  assign ramp = rq[43:36];

  always_ff @(posedge clk) begin
    sec1  <= work.sector;
    val1  <= work.val;
    sd1   <= 17'(work.sat * work.hue_dev);
    wz1   <= 14'(work.val * (PCT_MAX - work.sat));
    fz1   <= 11'((13'(work.val) * 13'd51) >> 2);
    sec2  <= sec1;
    p2    <= 24'(val1 * t2);
    zz2   <= zmul[19:4];
    full2 <= fmul[20:13];
    sec3  <= sec2;
    ry3   <= rmul[28:7];
    zero3 <= zq[29:22];
    full3 <= full2;
    unique case (sec3)
      SECT_RY: begin
        red <= full3; green <= ramp; blue <= zero3;
      end
      SECT_YG: begin
        red <= ramp; green <= full3; blue <= zero3;
      end
      SECT_GC: begin
        red <= zero3; green <= full3; blue <= ramp;
      end
      SECT_CB: begin
        red <= zero3; green <= ramp; blue <= full3;
      end
      SECT_BM: begin
        red <= ramp; green <= zero3; blue <= full3;
      end
      default: begin
        red <= full3; green <= zero3; blue <= ramp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      done <= vld3;
    end
  end

endmodule

// ===== hdl/hsv_to_rgb_auto_brightness.sv =====
// Timing: a taken word is written into the queue and then passes the back-end registers vld1,
// vld2, vld3 and done; red, green and blue are registered together with done.
// Throughput: one word per cycle; the back end drains the two-entry queue every cycle,
// so busy stays low outside reset; the queue slot and four pipeline stages lie between
// a word and its result.
// Reset: synchronous, active high; busy is high during reset, the queue and pipeline
// are emptied, and the automatic levels return to a minimum of 0 and a maximum of 100.
module hsv_to_rgb_auto_brightness (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvab_pkg::HUE_W-1:0]     hue,
  input  logic [hsvab_pkg::PCT_W-1:0]     saturation,
  input  logic [hsvab_pkg::PCT_W-1:0]     brightness,
  input  logic [hsvab_pkg::LIGHT_W-1:0]   light_level,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [hsvab_pkg::PCT_W-1:0]     cfg_data,
  output logic                            done,
  output logic [hsvab_pkg::CHAN_W-1:0]    red,
  output logic [hsvab_pkg::CHAN_W-1:0]    green,
  output logic [hsvab_pkg::CHAN_W-1:0]    blue
);
  import hsvab_pkg::*;

  `include "hsv_to_rgb_auto_brightness_assert.svh"

  logic [PCT_W-1:0] auto_min_level;
  logic [PCT_W-1:0] auto_max_level;
  work_t            front_work;
  work_t            head;
  logic             not_empty;
  logic             full;
  logic             accept;

  assign busy   = full || rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_min_level <= 7'd0;
      auto_max_level <= 7'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_MIN: auto_min_level <= cfg_data;
        REG_AUTO_MAX: auto_max_level <= cfg_data;
        default:      auto_max_level <= auto_max_level;
      endcase
    end
  end

  hsvab_front u_front (
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .light_level    (light_level),
    .auto_min_level (auto_min_level),
    .auto_max_level (auto_max_level),
    .work           (front_work)
  );

  hsvab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_work),
    .pop       (not_empty),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  hsvab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (not_empty),
    .work     (head),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  `HSVAB_ASSERT_ANY(a_rst_clears_done, rst |=> !done, "done high right after reset")
  `HSVAB_ASSERT_RUN(a_word_to_result, accept |-> ##5 done, "accepted word gave no result")
  `HSVAB_ASSERT_RUN(a_no_stray_result, done |-> $past(accept, 5), "result without a word")
  `HSVAB_ASSERT_RUN(a_queue_drains, !full, "queue filled although the back end never stalls")

endmodule
